[design/fsgs_pkg.sv]
// Shared types and constants for the falling-sand grid step core.
`timescale 1ns / 1ps
package fsgs_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_CELL_BITS  = 8;

  localparam int IN_BITS       = 32;
  localparam int OUT_BITS      = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 9;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EMPTY  = 2'd2;

  localparam logic [8:0] RST_WIDTH  = 9'd256;
  localparam logic [8:0] RST_HEIGHT = 9'd256;
  localparam logic [7:0] RST_EMPTY  = 8'd0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_STEP
  } core_state_t;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_RD_HERE,
    PS_CHK_HERE,
    PS_CHK_BELOW,
    PS_CHK_DL,
    PS_CHK_DR,
    PS_WR_SRC
  } pass_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pass_stat_t;

endpackage

[design/fsgs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fsgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/fsgs_pass.sv]
// Gravity pass sequencer: walks the grid bottom-up, read-check-move per cell.
`timescale 1ns / 1ps
module fsgs_pass #(
  parameter int MAX_WIDTH  = fsgs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fsgs_pkg::DEF_MAX_HEIGHT,
  parameter int CELL_BITS  = fsgs_pkg::DEF_CELL_BITS,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int UW = $clog2(MAX_WIDTH + 1),
  localparam int UH = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [UW-1:0]        used_w,
  input  logic [UH-1:0]        used_h,
  input  logic [CELL_BITS-1:0] empty,
  input  logic [CELL_BITS-1:0] rdata,
  output logic [RW+CW-1:0]     raddr,
  output logic                 we,
  output logic [RW+CW-1:0]     waddr,
  output logic [CELL_BITS-1:0] wdata,
  output fsgs_pkg::pass_stat_t stat
);

  import fsgs_pkg::*;

  pass_state_t          state, state_next;
  logic [RW-1:0]        row, row_next;
  logic [CW-1:0]        col, col_next;
  logic [CELL_BITS-1:0] val, val_next;

  logic [RW-1:0] row_dn;
  logic [CW-1:0] col_l, col_r;
  logic [UW-1:0] col_p1;
  logic          last_col, interior, is_empty, done;

  assign row_dn   = row + RW'(1);
  assign col_l    = col - CW'(1);
  assign col_r    = col + CW'(1);
  assign col_p1   = UW'(col) + UW'(1);
  assign last_col = (col_p1 == used_w);
  assign interior = (col != '0) && !last_col;
  assign is_empty = (rdata == empty);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PS_IDLE;
    end else begin
      state <= state_next;
    end
    row <= row_next;
    col <= col_next;
    val <= val_next;
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    val_next   = val;
    we         = 1'b0;
    waddr      = {row, col};
    wdata      = val;
    raddr      = {row, col};
    done       = 1'b0;
    unique case (state)
      PS_IDLE: begin
        if (start) begin
          row_next   = RW'(used_h - UH'(2));
          col_next   = '0;
          state_next = PS_RD_HERE;
        end
      end
      PS_RD_HERE: begin
        state_next = PS_CHK_HERE;
      end
      PS_CHK_HERE: begin
        raddr = {row_dn, col};
        if (!is_empty) begin
          val_next   = rdata;
          state_next = PS_CHK_BELOW;
        end
      end
      PS_CHK_BELOW: begin
        raddr = {row_dn, col_l};
        if (is_empty) begin
          we         = 1'b1;
          waddr      = {row_dn, col};
          state_next = PS_WR_SRC;
        end else if (interior) begin
          state_next = PS_CHK_DL;
        end
      end
      PS_CHK_DL: begin
        raddr = {row_dn, col_r};
        if (is_empty) begin
          we         = 1'b1;
          waddr      = {row_dn, col_l};
          state_next = PS_WR_SRC;
        end else begin
          state_next = PS_CHK_DR;
        end
      end
      PS_CHK_DR: begin
        if (is_empty) begin
          we         = 1'b1;
          waddr      = {row_dn, col_r};
          state_next = PS_WR_SRC;
        end
      end
      PS_WR_SRC: begin
        we    = 1'b1;
        wdata = empty;
      end
      default: begin
        state_next = PS_IDLE;
      end
    endcase

    // advance to the next cell once this one is settled
    if ((state == PS_CHK_HERE && is_empty) ||
        (state == PS_CHK_BELOW && !is_empty && !interior) ||
        (state == PS_CHK_DR && !is_empty) ||
        (state == PS_WR_SRC)) begin
      if (last_col) begin
        if (row == '0) begin
          done       = 1'b1;
          state_next = PS_IDLE;
        end else begin
          row_next   = row - RW'(1);
          col_next   = '0;
          state_next = PS_RD_HERE;
        end
      end else begin
        col_next   = col_r;
        state_next = PS_RD_HERE;
      end
    end
  end

  assign stat.busy = (state != PS_IDLE);
  assign stat.done = done;

endmodule

[design/falling_sand_grid_step_core.sv]
// Top level: command stream, config registers, cell store and gravity pass.
//
// Input stream s_*: one word per command (write cell, read cell, gravity step).
// Output stream m_*: exactly one result word per command, in command order.
// Config port cfg_*: grid width, grid height and empty code; write only while
// no command is in flight.
// Command flow: a write, an out-of-grid access or an unused code returns its
// result at the edge it is taken, one word per cycle while m_tready is high.
// A read passes through the RAM's registered read and the ST_READ state.
// A gravity step visits (height-1)*width cells: one RAM read for the cell
// and one per neighbor checked, and one write each for destination and source
// on a move, all on the single RAM port pair.
// Reset: config registers return to their defaults, then a clearing pass
// writes zero into all 2**(RW+CW) RAM entries, during which s_tready stays
// low.
// Stall: the result sits in the output register until m_tready; a new command
// is taken only when that register is empty or being drained the same cycle.
`timescale 1ns / 1ps
module falling_sand_grid_step_core #(
  parameter int MAX_WIDTH  = fsgs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fsgs_pkg::DEF_MAX_HEIGHT,
  parameter int CELL_BITS  = fsgs_pkg::DEF_CELL_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // operation[1:0], cell_row[9:2], cell_column[17:10], cell_value[25:18]
  input  logic [fsgs_pkg::IN_BITS-1:0]       s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // read_value[7:0], step_done[8], access_error[9]
  output logic [fsgs_pkg::OUT_BITS-1:0]      m_tdata,
  input  logic                               cfg_we,
  input  logic [fsgs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fsgs_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  import fsgs_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = RW + CW;
  localparam int UW = $clog2(MAX_WIDTH + 1);
  localparam int UH = $clog2(MAX_HEIGHT + 1);
  localparam int XW = (UW > 9) ? ((UW > UH) ? UW : UH) : ((UH > 9) ? UH : 9);

  logic [8:0] grid_width, grid_height;
  logic [7:0] empty_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= RST_WIDTH;
      grid_height <= RST_HEIGHT;
      empty_code  <= RST_EMPTY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  grid_width  <= cfg_data;
        CFG_HEIGHT: grid_height <= cfg_data;
        CFG_EMPTY:  empty_code  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [UW-1:0]        used_w;
  logic [UH-1:0]        used_h;
  logic [CELL_BITS-1:0] empty;

  always_comb begin
    if (grid_width == '0) begin
      used_w = UW'(1);
    end else if (XW'(grid_width) > XW'(MAX_WIDTH)) begin
      used_w = UW'(MAX_WIDTH);
    end else begin
      used_w = UW'(grid_width);
    end
    if (grid_height < 9'd2) begin
      used_h = UH'(2);
    end else if (XW'(grid_height) > XW'(MAX_HEIGHT)) begin
      used_h = UH'(MAX_HEIGHT);
    end else begin
      used_h = UH'(grid_height);
    end
  end

  assign empty = CELL_BITS'(empty_code);

  logic [1:0] in_op;
  logic [7:0] in_row, in_col, in_val;
  logic       in_err, acc;

  assign in_op  = s_tdata[1:0];
  assign in_row = s_tdata[9:2];
  assign in_col = s_tdata[17:10];
  assign in_val = s_tdata[25:18];
  assign in_err = (XW'(in_row) >= XW'(used_h)) || (XW'(in_col) >= XW'(used_w));
  assign acc    = s_tvalid && s_tready;

  core_state_t state, state_next;
  logic [AW-1:0] clr_cnt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [CELL_BITS-1:0] ram_wdata, ram_rdata;

  logic [AW-1:0]        pass_raddr, pass_waddr;
  logic                 pass_we, pass_start;
  logic [CELL_BITS-1:0] pass_wdata;
  pass_stat_t           pass_stat;

  logic       out_load;
  logic [7:0] out_read, out_read_next;
  logic       out_done, out_done_next, out_err, out_err_next;

  fsgs_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fsgs_pass #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CELL_BITS  (CELL_BITS)
  ) u_pass (
    .clk    (clk),
    .rst    (rst),
    .start  (pass_start),
    .used_w (used_w),
    .used_h (used_h),
    .empty  (empty),
    .rdata  (ram_rdata),
    .raddr  (pass_raddr),
    .we     (pass_we),
    .waddr  (pass_waddr),
    .wdata  (pass_wdata),
    .stat   (pass_stat)
  );

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (out_load) begin
      out_read <= out_read_next;
      out_done <= out_done_next;
      out_err  <= out_err_next;
    end
  end

  always_comb begin
    state_next    = state;
    out_load      = 1'b0;
    out_read_next = '0;
    out_done_next = 1'b0;
    out_err_next  = 1'b0;
    pass_start    = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = {RW'(in_row), CW'(in_col)};
    ram_wdata     = CELL_BITS'(in_val);
    ram_raddr     = {RW'(in_row), CW'(in_col)};
    if (pass_stat.busy) begin
      ram_we    = pass_we;
      ram_waddr = pass_waddr;
      ram_wdata = pass_wdata;
      ram_raddr = pass_raddr;
    end
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
        if (&clr_cnt) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          case (in_op)
            OP_WRITE: begin
              out_load     = 1'b1;
              out_err_next = in_err;
              ram_we       = !in_err;
            end
            OP_READ: begin
              if (in_err) begin
                out_load     = 1'b1;
                out_err_next = 1'b1;
              end else begin
                state_next = ST_READ;
              end
            end
            OP_STEP: begin
              pass_start = 1'b1;
              state_next = ST_STEP;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_load      = 1'b1;
        out_read_next = 8'(ram_rdata);
        state_next    = ST_IDLE;
      end
      ST_STEP: begin
        if (pass_stat.done) begin
          out_load      = 1'b1;
          out_done_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_tdata = OUT_BITS'({out_err, out_done, out_read});

endmodule

[design/fsgs_checker.sv]
// Port-level checks for the falling-sand grid step core, bound to the top level.
`timescale 1ns / 1ps
module fsgs_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [fsgs_pkg::OUT_BITS-1:0]      m_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // a step result and an access error never share a word
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
    else $error("step_done and access_error both set");

  // only a good read carries a value
  a_flag_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[8] || m_tdata[9]) |-> m_tdata[7:0] == 8'd0)
    else $error("nonzero read_value on step or error word");

  // no command taken while an older result is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !m_tvalid || m_tready)
    else $error("command accepted over a stalled result");

  // the store is being cleared right after reset
  a_clear_after_rst: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("block ready right after reset");

endmodule

bind falling_sand_grid_step_core fsgs_checker u_fsgs_checker (.*);
